### hw/rtl/led_matrix_glyph_scroller_core_defines.svh
// Assertion macros shared by the glyph scroller RTL.
`ifndef LED_MATRIX_GLYPH_SCROLLER_CORE_DEFINES_SVH
`define LED_MATRIX_GLYPH_SCROLLER_CORE_DEFINES_SVH
`ifndef SYNTH
`define LMGS_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LMGS_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LMGS_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define LMGS_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

### hw/rtl/lmgs_pkg.sv
// Types and constants shared by the glyph scroller modules.
package lmgs_pkg;

   localparam int GLYPH_ROWS       = 8;
   localparam int GLYPH_BITS       = 8;
   localparam int OUT_BITS         = 32;
   localparam int SEGMENTS_DEFAULT = 4;
   localparam logic [3:0] EMPTY_WIDTH = 4'd5;

   typedef struct packed {
      logic [GLYPH_BITS-1:0] glyph_row_0;
      logic [GLYPH_BITS-1:0] glyph_row_1;
      logic [GLYPH_BITS-1:0] glyph_row_2;
      logic [GLYPH_BITS-1:0] glyph_row_3;
      logic [GLYPH_BITS-1:0] glyph_row_4;
      logic [GLYPH_BITS-1:0] glyph_row_5;
      logic [GLYPH_BITS-1:0] glyph_row_6;
      logic [GLYPH_BITS-1:0] glyph_row_7;
   } req_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] frame_row_0;
      logic [OUT_BITS-1:0] frame_row_1;
      logic [OUT_BITS-1:0] frame_row_2;
      logic [OUT_BITS-1:0] frame_row_3;
      logic [OUT_BITS-1:0] frame_row_4;
      logic [OUT_BITS-1:0] frame_row_5;
      logic [OUT_BITS-1:0] frame_row_6;
      logic [OUT_BITS-1:0] frame_row_7;
      logic                last_frame;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   typedef struct packed {
      logic       load;
      logic       step;
      logic       last;
      logic [2:0] sel;
   } ctl_type;

endpackage

### hw/rtl/lmgs_seq.sv
// Sequencer: glyph width detection, column counter and output handshake.
module lmgs_seq import lmgs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output ctl_type ctl
);

   state_type  state_ff, state_in;
   logic [3:0] col_ff, col_in;
   logic [3:0] wid_ff, wid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [GLYPH_BITS-1:0] any_bits;
   logic [3:0] width;

   always_comb begin
      any_bits = req_word.glyph_row_0 | req_word.glyph_row_1 | req_word.glyph_row_2 |
                 req_word.glyph_row_3 | req_word.glyph_row_4 | req_word.glyph_row_5 |
                 req_word.glyph_row_6 | req_word.glyph_row_7;
      width = EMPTY_WIDTH;
      for (int i = 0; i < GLYPH_BITS; i++) begin
         if (any_bits[i]) begin
            width = 4'(i + 1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         col_ff       <= '0;
         wid_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         wid_ff       <= wid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      wid_in   = wid_ff;
      ctl.load = 1'b0;
      ctl.step = 1'b0;
      ctl.last = (col_ff == wid_ff);
      ctl.sel  = 3'(width - 4'd1);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               col_in   = '0;
               wid_in   = width;
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl.step = 1'b1;
               col_in   = col_ff + 4'd1;
               if (ctl.last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (ctl.step) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/lmgs_shift.sv
// Shift datapath: glyph column extraction, frame store and output register.
module lmgs_shift import lmgs_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  ctl_type ctl,
   input  req_type req_word,
   output rsp_type rsp_word
);

   localparam int FRAME_BITS = SEGMENTS * 8;

   logic [GLYPH_BITS-1:0] glyph_ff [GLYPH_ROWS];
   logic [GLYPH_BITS-1:0] glyph_in [GLYPH_ROWS];
   logic [GLYPH_BITS-1:0] rows     [GLYPH_ROWS];
   logic [2:0]            sel_ff;
   logic [FRAME_BITS-1:0] frame_ff [GLYPH_ROWS];
   logic [FRAME_BITS-1:0] frame_in [GLYPH_ROWS];
   logic [FRAME_BITS-1:0] lit      [GLYPH_ROWS];
   logic [OUT_BITS-1:0]   fit      [GLYPH_ROWS];
   rsp_type               rsp_ff, rsp_in;

   assign rows[0] = req_word.glyph_row_0;
   assign rows[1] = req_word.glyph_row_1;
   assign rows[2] = req_word.glyph_row_2;
   assign rows[3] = req_word.glyph_row_3;
   assign rows[4] = req_word.glyph_row_4;
   assign rows[5] = req_word.glyph_row_5;
   assign rows[6] = req_word.glyph_row_6;
   assign rows[7] = req_word.glyph_row_7;

   always_comb begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
         lit[r]      = frame_ff[r] | {{(FRAME_BITS-1){1'b0}}, glyph_ff[r][sel_ff]};
         frame_in[r] = {lit[r][FRAME_BITS-2:0], 1'b0};
         glyph_in[r] = {glyph_ff[r][GLYPH_BITS-2:0], 1'b0};
      end
   end

   for (genvar r = 0; r < GLYPH_ROWS; r++) begin : g_fit
      if (FRAME_BITS >= OUT_BITS) begin : g_trunc
         assign fit[r] = lit[r][OUT_BITS-1:0];
      end else begin : g_pad
         assign fit[r] = {{(OUT_BITS-FRAME_BITS){1'b0}}, lit[r]};
      end
   end

   always_comb begin
      rsp_in.frame_row_0 = fit[0];
      rsp_in.frame_row_1 = fit[1];
      rsp_in.frame_row_2 = fit[2];
      rsp_in.frame_row_3 = fit[3];
      rsp_in.frame_row_4 = fit[4];
      rsp_in.frame_row_5 = fit[5];
      rsp_in.frame_row_6 = fit[6];
      rsp_in.frame_row_7 = fit[7];
      rsp_in.last_frame  = ctl.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            frame_ff[r] <= '0;
         end
      end else if (ctl.step) begin
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            frame_ff[r] <= frame_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         sel_ff <= ctl.sel;
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            glyph_ff[r] <= rows[r];
         end
      end else if (ctl.step) begin
         for (int r = 0; r < GLYPH_ROWS; r++) begin
            glyph_ff[r] <= glyph_in[r];
         end
      end
      if (ctl.step) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_word = rsp_ff;

endmodule

### hw/rtl/led_matrix_glyph_scroller_core.sv
// Top level of the scrolling glyph marquee for an 8-row LED matrix.
//
// The req channel takes one 8x8 glyph per word; the rsp channel returns
// one frame word per scroll step, eight rows of the display plus a flag on
// the final frame of the glyph. A glyph of width w (highest lit column,
// five for a blank glyph) yields w + 1 frames, the last one a blank gap.
// An accepted glyph is loaded, then stepped once per frame by the single
// shared row shifter. The first frame is registered on the first scroll
// step that follows the load cycle.
// While a glyph is scrolling, req_stall is high; it drops on the cycle after
// the last frame is produced, even if that frame still waits in the output
// register. A stalled rsp word holds, and the shifter waits for it.
// Reset clears the frame store to all dark and empties the output register.
// The frame store is never cleared between glyphs, so text scrolls on.
module led_matrix_glyph_scroller_core import lmgs_pkg::*; #(
   parameter int SEGMENTS = SEGMENTS_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_word,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_word
);

`include "led_matrix_glyph_scroller_core_defines.svh"

   ctl_type ctl;

   lmgs_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   lmgs_shift #(
      .SEGMENTS (SEGMENTS)
   ) u_shift (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_word (req_word),
      .rsp_word (rsp_word)
   );

   `LMGS_ASSERT_NXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted glyph did not make the block busy")
   `LMGS_ASSERT_NXT(a_step_gives_valid, clock, reset, ctl.step, rsp_valid && (rsp_word.last_frame == $past(ctl.last)), "produced frame not presented")
   `LMGS_ASSERT_NXT(a_last_frees_input, clock, reset, ctl.step && ctl.last, !req_stall, "block stayed busy after last frame")
   `LMGS_ASSERT_IMP(a_load_step_apart, clock, reset, ctl.load, !ctl.step && !req_stall, "load and step overlapped")

endmodule

### tb/testbench.sv
// Self-checking testbench for the LED matrix glyph scroller core.
`timescale 1ns / 100ps

module testbench;
   import lmgs_pkg::*;

   localparam int FRAME_BITS  = (SEGMENTS_DEFAULT * 8 > 64) ? 64 : SEGMENTS_DEFAULT * 8;
   localparam int HOLD_CYCLES = 150;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   req_type     glyph_queue[$];
   rsp_type     frames_due[$];
   logic [63:0] frame_rows[8];
   logic [63:0] row_mask = {64{1'b1}} >> (64 - FRAME_BITS);
   logic        glyph_taken = 1'b0;
   int          sender_idle_pct = 0;
   int          recv_stall_pct  = 0;
   logic        hold_phase = 1'b0;
   int          hold_count = 0;
   int          mismatch_count = 0;
   int          frames_seen = 0;

   led_matrix_glyph_scroller_core #(.SEGMENTS(SEGMENTS_DEFAULT)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      for (int r = 0; r < 8; r++) frame_rows[r] = '0;
   end

   function automatic void scroll_glyph(input req_type g);
      logic [7:0]  rows[8];
      logic [7:0]  aligned[8];
      logic [7:0]  lit;
      logic [63:0] column_bit;
      logic [31:0] shown[8];
      rsp_type     frame;
      int          width;
      rows[0] = g.glyph_row_0;
      rows[1] = g.glyph_row_1;
      rows[2] = g.glyph_row_2;
      rows[3] = g.glyph_row_3;
      rows[4] = g.glyph_row_4;
      rows[5] = g.glyph_row_5;
      rows[6] = g.glyph_row_6;
      rows[7] = g.glyph_row_7;
      lit = '0;
      for (int r = 0; r < 8; r++) lit |= rows[r];
      width = 0;
      for (int b = 0; b < 8; b++) if (lit[b]) width = b + 1;
      if (lit == '0) width = int'(EMPTY_WIDTH);
      for (int r = 0; r < 8; r++) aligned[r] = rows[r] << (8 - width);
      for (int col = 0; col <= width; col++) begin
         for (int r = 0; r < 8; r++) begin
            column_bit = '0;
            if (col < 8) column_bit[0] = aligned[r][7 - col];
            frame_rows[r] = (frame_rows[r] | column_bit) & row_mask;
            shown[r] = frame_rows[r][31:0];
         end
         frame.frame_row_0 = shown[0];
         frame.frame_row_1 = shown[1];
         frame.frame_row_2 = shown[2];
         frame.frame_row_3 = shown[3];
         frame.frame_row_4 = shown[4];
         frame.frame_row_5 = shown[5];
         frame.frame_row_6 = shown[6];
         frame.frame_row_7 = shown[7];
         frame.last_frame  = (col == width);
         frames_due.push_back(frame);
         for (int r = 0; r < 8; r++) frame_rows[r] = (frame_rows[r] << 1) & row_mask;
      end
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < 40)
         $display("frame %0d %s: got %h, want %h", frames_seen, field, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      logic [$bits(rsp_type)-1:0] got_bits;
      logic [$bits(rsp_type)-1:0] want_bits;
      rsp_type                    want;
      glyph_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            report_mismatch("unexpected word", 32'd0, 32'd0);
         end else begin
            want = frames_due.pop_front();
            got_bits = rsp_word;
            want_bits = want;
            for (int r = 0; r < 8; r++)
               if (got_bits[1 + 32 * (7 - r) +: 32] !== want_bits[1 + 32 * (7 - r) +: 32])
                  report_mismatch($sformatf("frame_row_%0d", r),
                                  got_bits[1 + 32 * (7 - r) +: 32],
                                  want_bits[1 + 32 * (7 - r) +: 32]);
            if (rsp_word.last_frame !== want.last_frame)
               report_mismatch("last_frame", 32'(rsp_word.last_frame), 32'(want.last_frame));
         end
         frames_seen++;
      end
      if (!reset && req_valid && !req_stall) scroll_glyph(req_word);
   end

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || glyph_taken) begin
         if (glyph_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
            req_word  <= glyph_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_phase && hold_count < HOLD_CYCLES) begin
         rsp_stall  <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   function automatic req_type random_glyph();
      logic [63:0] bits;
      logic [7:0]  keep;
      int          kind;
      bits = {$urandom, $urandom};
      kind = $urandom_range(9);
      if (kind == 0) begin
         bits = '0;
      end else if (kind >= 2) begin
         keep = 8'hFF >> (8 - $urandom_range(1, 8));
         bits &= {8{keep}};
      end
      return req_type'(bits);
   endfunction

   task automatic queue_random(input int count);
      repeat (count) glyph_queue.push_back(random_glyph());
   endtask

   task automatic wait_drained();
      while (glyph_queue.size() != 0 || req_valid || frames_due.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      logic [63:0] pixel;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      glyph_queue.push_back(req_type'(64'h0));
      glyph_queue.push_back(req_type'(64'hFFFF_FFFF_FFFF_FFFF));
      glyph_queue.push_back(req_type'(64'h0100_0000_0000_0000));
      glyph_queue.push_back(req_type'(64'h0000_0000_0000_0080));
      for (int k = 1; k < 7; k++) begin
         pixel = '0;
         pixel[8 * (7 - k) + k] = 1'b1;
         glyph_queue.push_back(req_type'(pixel));
      end
      glyph_queue.push_back(req_type'(64'hAA55_AA55_AA55_AA55));
      glyph_queue.push_back(req_type'(64'h8080_8080_8080_8080));
      glyph_queue.push_back(req_type'(64'h0101_0101_0101_0101));
      glyph_queue.push_back(req_type'(64'h0));
      glyph_queue.push_back(req_type'(64'h0));
      glyph_queue.push_back(req_type'(64'hFFFF_FFFF_FFFF_FFFF));
      glyph_queue.push_back(req_type'(64'hFFFF_FFFF_FFFF_FFFF));
      glyph_queue.push_back(req_type'(64'hFFFF_FFFF_FFFF_FFFF));
      glyph_queue.push_back(req_type'(64'h0));
      glyph_queue.push_back(req_type'(64'h0));
      wait_drained();

      queue_random(20);
      wait_drained();

      sender_idle_pct = 66;
      queue_random(35);
      wait_drained();

      sender_idle_pct = 0;
      recv_stall_pct  = 66;
      queue_random(35);
      wait_drained();

      sender_idle_pct = 17;
      recv_stall_pct  = 17;
      queue_random(30);
      wait_drained();

      sender_idle_pct = 0;
      recv_stall_pct  = 0;
      hold_phase      = 1'b1;
      queue_random(30);
      wait_drained();

      repeat (12) @(negedge clock);
      if (mismatch_count == 0 && frames_due.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   initial begin
      #200000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/lmgs_pkg.sv
hw/rtl/lmgs_seq.sv
hw/rtl/lmgs_shift.sv
hw/rtl/led_matrix_glyph_scroller_core.sv
tb/testbench.sv
